/* rtl/fcpdm_pkg.sv */
`timescale 1ns / 1ps
// shared constants, register indexes and state type for the frequency
// calibrate / peak capture / dac map block; no dependencies
package fcpdm_pkg;

    localparam int RawW   = 16;
    localparam int ByteW  = 8;
    localparam int LimW   = 14;
    localparam int OffW   = 11;
    localparam int CalW   = 16;
    localparam int PeakW  = 15;
    localparam int CodeW  = 8;
    localparam int NumW   = 17;
    localparam int TriW   = 18;
    localparam int ProdW  = 22;
    localparam int CfgIdxW = 2;

    // one quotient bit per cycle over the whole product
    localparam int DivSteps = ProdW;
    localparam int CntW     = $clog2(DivSteps);

    localparam logic [RawW-1:0]  RawMax     = 16'd31867;
    localparam logic [PeakW-1:0] LowFreq    = 15'd500;
    localparam logic [LimW-1:0]  LimFloor   = 14'd500;
    localparam logic [CodeW-1:0] ZeroCode   = 8'd0;
    localparam logic [CodeW-1:0] LowCode    = 8'd51;
    localparam logic [CodeW-1:0] FullCode   = 8'd255;
    localparam logic [NumW-1:0]  LinearBias = 17'd2500;
    localparam logic [CalW-1:0]  CalMax     = 16'h7FFF;
    localparam logic [LimW-1:0]  LimReset   = 14'd2000;
    localparam logic [OffW-1:0]  OffReset   = 11'd0;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_UPPER_LIMIT = 2'd0,
        CFG_CAL_OFFSET  = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* rtl/frequency_calibrate_peak_dac_map_unit.sv */
`timescale 1ns / 1ps
// frequency calibrate, peak capture and dac code mapping, top level
// depends on fcpdm_pkg
//
// usage
//   in channel (in_valid/in_ready): one request per refresh with raw_freq and
//   the three bcd clock bytes. a raw value above 31867 is taken and dropped.
//   cfg channel (cfg_valid/cfg_ready, always ready): index 0 upper_limit,
//   index 1 calibration_offset; other indexes are ignored. write only while idle.
//   out channel (out_valid/out_ready): calibrated_freq, dac_code and the peak
//   frequency with its clock bytes, after this request's peak update.
// sequencing
//   a request whose code is a fixed value goes from ST_CALC straight to ST_DONE;
//   on the linear segment ST_CALC is followed by the shift-add steps ST_MUL1
//   (*3) and ST_MUL2 (*17) for the *51, then a restoring divider that yields one
//   quotient bit per cycle. in_ready is high only while the sequencer is idle,
//   so one request is in flight at a time; a dropped request leaves the
//   sequencer idle.
// reset and stall
//   reset clears the peak and its clock bytes, loads upper_limit 2000 and
//   offset 0, and empties the output register. a finished result sits in the
//   output register while the next request is taken; if the receiver stalls
//   with both full, the sequencer waits in its last step.
module frequency_calibrate_peak_dac_map_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcpdm_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [fcpdm_pkg::LimW-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fcpdm_pkg::RawW-1:0]        raw_freq,
    input  logic [fcpdm_pkg::ByteW-1:0]       clock_hour,
    input  logic [fcpdm_pkg::ByteW-1:0]       clock_minute,
    input  logic [fcpdm_pkg::ByteW-1:0]       clock_second,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fcpdm_pkg::CalW-1:0] calibrated_freq,
    output logic [fcpdm_pkg::CodeW-1:0]       dac_code,
    output logic [fcpdm_pkg::PeakW-1:0]       peak_freq,
    output logic [fcpdm_pkg::ByteW-1:0]       peak_hour,
    output logic [fcpdm_pkg::ByteW-1:0]       peak_minute,
    output logic [fcpdm_pkg::ByteW-1:0]       peak_second
);

    fcpdm_pkg::state_t state_reg, state_next;

    logic [fcpdm_pkg::LimW-1:0]  lim_reg;
    logic [fcpdm_pkg::OffW-1:0]  off_reg;

    logic [fcpdm_pkg::CalW-1:0]  f_reg;
    logic [fcpdm_pkg::ByteW-1:0] hour_reg, minute_reg, second_reg;
    logic [fcpdm_pkg::NumW-1:0]  num_reg;
    logic [fcpdm_pkg::TriW-1:0]  tri_reg;
    logic [fcpdm_pkg::ProdW-1:0] quo_reg;
    logic [fcpdm_pkg::LimW-1:0]  rem_reg;
    logic [fcpdm_pkg::LimW-1:0]  div_reg;
    logic [fcpdm_pkg::CodeW-1:0] code_reg;
    logic [fcpdm_pkg::CntW-1:0]  cnt_reg;

    logic [fcpdm_pkg::PeakW-1:0] peak_reg;
    logic [fcpdm_pkg::ByteW-1:0] peak_hour_reg, peak_minute_reg, peak_second_reg;

    logic                        out_valid_reg;
    logic [fcpdm_pkg::CalW-1:0]  out_f_reg;
    logic [fcpdm_pkg::CodeW-1:0] out_code_reg;
    logic [fcpdm_pkg::PeakW-1:0] out_peak_reg;
    logic [fcpdm_pkg::ByteW-1:0] out_hour_reg, out_minute_reg, out_second_reg;

    logic                        in_acc;
    logic                        raw_ok;
    logic [fcpdm_pkg::CalW:0]    sum_w;
    logic [fcpdm_pkg::CalW-1:0]  f_sat;
    logic                        f_neg, f_low, lim_low, f_high, fixed_code;
    logic [fcpdm_pkg::CodeW-1:0] fixed_value;
    logic                        peak_upd;
    logic                        slot_free;
    logic                        div_last;
    logic [fcpdm_pkg::LimW:0]    rem_shift;
    logic [fcpdm_pkg::LimW:0]    rem_diff;
    logic                        rem_ge;

    // sequencer strobes
    logic load_en, calc_en, mul1_en, mul2_en, div_en, done_en;

    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign raw_ok    = (raw_freq <= fcpdm_pkg::RawMax);
    assign slot_free = !out_valid_reg || out_ready;
    assign div_last  = (cnt_reg == fcpdm_pkg::CntW'(fcpdm_pkg::DivSteps - 1));

    // raw plus sign-extended offset, saturated at the positive limit
    assign sum_w = {1'b0, raw_freq}
                 + {{(fcpdm_pkg::CalW + 1 - fcpdm_pkg::OffW){off_reg[fcpdm_pkg::OffW-1]}},
                    off_reg};
    always_comb
    begin
        if (!sum_w[fcpdm_pkg::CalW] && sum_w[fcpdm_pkg::CalW-1])
        begin
            f_sat = fcpdm_pkg::CalMax;
        end
        else
        begin
            f_sat = sum_w[fcpdm_pkg::CalW-1:0];
        end
    end

    // segment selection on the calibrated value
    assign f_neg      = f_reg[fcpdm_pkg::CalW-1];
    assign f_low      = (f_reg[fcpdm_pkg::PeakW-1:0] < fcpdm_pkg::LowFreq);
    assign lim_low    = (lim_reg <= fcpdm_pkg::LimFloor);
    assign f_high     = (f_reg[fcpdm_pkg::PeakW-1:0] > {1'b0, lim_reg});
    assign fixed_code = f_neg || f_low || lim_low || f_high;
    always_comb
    begin
        if (f_neg)
        begin
            fixed_value = fcpdm_pkg::ZeroCode;
        end
        else if (f_low)
        begin
            fixed_value = fcpdm_pkg::LowCode;
        end
        else
        begin
            fixed_value = fcpdm_pkg::FullCode;
        end
    end

    assign peak_upd = !f_neg && (f_reg[fcpdm_pkg::PeakW-1:0] > peak_reg);

    // restoring divide step, one dividend bit shifted in per cycle
    assign rem_shift = {rem_reg, quo_reg[fcpdm_pkg::ProdW-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcpdm_pkg::ST_IDLE:
            begin
                if (in_acc && raw_ok)
                begin
                    state_next = fcpdm_pkg::ST_CALC;
                end
            end
            fcpdm_pkg::ST_CALC:
            begin
                if (fixed_code)
                begin
                    state_next = fcpdm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = fcpdm_pkg::ST_MUL1;
                end
            end
            fcpdm_pkg::ST_MUL1: state_next = fcpdm_pkg::ST_MUL2;
            fcpdm_pkg::ST_MUL2: state_next = fcpdm_pkg::ST_DIV;
            fcpdm_pkg::ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = fcpdm_pkg::ST_DONE;
                end
            end
            fcpdm_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = fcpdm_pkg::ST_IDLE;
                end
            end
            default: state_next = fcpdm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_en  = 1'b0;
        calc_en  = 1'b0;
        mul1_en  = 1'b0;
        mul2_en  = 1'b0;
        div_en   = 1'b0;
        done_en  = 1'b0;
        case (state_reg)
            fcpdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                load_en  = in_valid && raw_ok;
            end
            fcpdm_pkg::ST_CALC: calc_en = 1'b1;
            fcpdm_pkg::ST_MUL1: mul1_en = 1'b1;
            fcpdm_pkg::ST_MUL2: mul2_en = 1'b1;
            fcpdm_pkg::ST_DIV:  div_en  = 1'b1;
            fcpdm_pkg::ST_DONE: done_en = slot_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcpdm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= fcpdm_pkg::LimReset;
            off_reg <= fcpdm_pkg::OffReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fcpdm_pkg::cfg_index_t'(cfg_index))
                fcpdm_pkg::CFG_UPPER_LIMIT: lim_reg <= cfg_data;
                fcpdm_pkg::CFG_CAL_OFFSET:  off_reg <= cfg_data[fcpdm_pkg::OffW-1:0];
                default:
                begin
                    lim_reg <= lim_reg;
                end
            endcase
        end
    end

    // peak state and control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg        <= '0;
            peak_hour_reg   <= '0;
            peak_minute_reg <= '0;
            peak_second_reg <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (calc_en && peak_upd)
            begin
                peak_reg        <= f_reg[fcpdm_pkg::PeakW-1:0];
                peak_hour_reg   <= hour_reg;
                peak_minute_reg <= minute_reg;
                peak_second_reg <= second_reg;
            end
            if (mul2_en)
            begin
                cnt_reg <= '0;
            end
            else if (div_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (done_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            f_reg      <= f_sat;
            hour_reg   <= clock_hour;
            minute_reg <= clock_minute;
            second_reg <= clock_second;
        end
        if (calc_en)
        begin
            // 4f + limit - 2500, only used when 500 <= f <= limit
            num_reg  <= {f_reg[fcpdm_pkg::PeakW-1:0], 2'b00}
                      + {{(fcpdm_pkg::NumW - fcpdm_pkg::LimW){1'b0}}, lim_reg}
                      - fcpdm_pkg::LinearBias;
            div_reg  <= lim_reg - fcpdm_pkg::LimFloor;
            code_reg <= fixed_value;
        end
        if (mul1_en)
        begin
            // num * 3
            tri_reg <= {1'b0, num_reg} + {num_reg, 1'b0};
        end
        if (mul2_en)
        begin
            // (num * 3) * 17 = num * 51
            quo_reg <= {tri_reg, 4'b0000} + {4'b0000, tri_reg};
            rem_reg <= '0;
        end
        if (div_en)
        begin
            quo_reg <= {quo_reg[fcpdm_pkg::ProdW-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[fcpdm_pkg::LimW-1:0]
                              : rem_shift[fcpdm_pkg::LimW-1:0];
            if (div_last)
            begin
                code_reg <= {quo_reg[fcpdm_pkg::CodeW-2:0], rem_ge};
            end
        end
        if (done_en)
        begin
            out_f_reg      <= f_reg;
            out_code_reg   <= code_reg;
            out_peak_reg   <= peak_reg;
            out_hour_reg   <= peak_hour_reg;
            out_minute_reg <= peak_minute_reg;
            out_second_reg <= peak_second_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign calibrated_freq = $signed(out_f_reg);
    assign dac_code        = out_code_reg;
    assign peak_freq       = out_peak_reg;
    assign peak_hour       = out_hour_reg;
    assign peak_minute     = out_minute_reg;
    assign peak_second     = out_second_reg;

endmodule

/* rtl/fcpdm_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the frequency calibrate / dac map unit, bound to the top
// depends on fcpdm_pkg and frequency_calibrate_peak_dac_map_unit
module fcpdm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [fcpdm_pkg::CalW-1:0] calibrated_freq,
    input logic [fcpdm_pkg::CodeW-1:0]       dac_code,
    input logic [fcpdm_pkg::PeakW-1:0]       peak_freq
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(calibrated_freq)
            && $stable(dac_code) && $stable(peak_freq))
        else $error("result changed while stalled");

    // negative frequency maps to code zero
    a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibrated_freq[fcpdm_pkg::CalW-1] |-> dac_code == fcpdm_pkg::ZeroCode)
        else $error("negative frequency with nonzero code");

    // low segment gives the fixed low code
    a_low_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated_freq[fcpdm_pkg::CalW-1]
            && calibrated_freq[fcpdm_pkg::PeakW-1:0] < fcpdm_pkg::LowFreq
        |-> dac_code == fcpdm_pkg::LowCode)
        else $error("low frequency with wrong code");

    // the reported peak already covers this request's frequency
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !calibrated_freq[fcpdm_pkg::CalW-1]
        |-> peak_freq >= calibrated_freq[fcpdm_pkg::PeakW-1:0])
        else $error("peak below current frequency");

endmodule

bind frequency_calibrate_peak_dac_map_unit fcpdm_checker u_fcpdm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .calibrated_freq (calibrated_freq),
    .dac_code        (dac_code),
    .peak_freq       (peak_freq)
);

/* tb/frequency_calibrate_peak_dac_map_unit_test.sv */
`timescale 1ns / 1ps
// testbench for frequency_calibrate_peak_dac_map_unit: directed table, then random phases,
// then high-end rows; rows with given values are held to them, every other result to a
// local calibrate / peak / dac predictor; depends on fcpdm_pkg and the rtl of the unit
module frequency_calibrate_peak_dac_map_unit_test;

    localparam int HalfPeriod    = 10;
    localparam int CycleLimit    = 500000;
    localparam int SettleCycles  = 40;
    localparam int LongHold      = 400;
    localparam int PhaseCount    = 12;
    localparam int ItemsPerPhase = 62;

    typedef struct {
        logic signed [fcpdm_pkg::CalW-1:0] cal;
        logic [fcpdm_pkg::CodeW-1:0]       code;
        logic [fcpdm_pkg::PeakW-1:0]       peak;
        logic [fcpdm_pkg::ByteW-1:0]       hour;
        logic [fcpdm_pkg::ByteW-1:0]       minute;
        logic [fcpdm_pkg::ByteW-1:0]       second;
    } reading_t;

    typedef enum logic {PLAN_REFRESH, PLAN_WRITE} plan_kind_t;

    typedef struct {
        plan_kind_t                  kind;
        logic [fcpdm_pkg::RawW-1:0]  raw;
        logic [fcpdm_pkg::ByteW-1:0] hr;
        logic [fcpdm_pkg::ByteW-1:0] mn;
        logic [fcpdm_pkg::ByteW-1:0] sc;
        bit                          typed;
        reading_t                    want;
        logic [fcpdm_pkg::LimW-1:0]  limit;
        logic [fcpdm_pkg::LimW-1:0]  offset;
    } plan_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [fcpdm_pkg::CfgIdxW-1:0] cfg_index;
    logic [fcpdm_pkg::LimW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [fcpdm_pkg::RawW-1:0] raw_freq;
    logic [fcpdm_pkg::ByteW-1:0] clock_hour;
    logic [fcpdm_pkg::ByteW-1:0] clock_minute;
    logic [fcpdm_pkg::ByteW-1:0] clock_second;
    logic out_valid;
    logic out_ready;
    logic signed [fcpdm_pkg::CalW-1:0] calibrated_freq;
    logic [fcpdm_pkg::CodeW-1:0] dac_code;
    logic [fcpdm_pkg::PeakW-1:0] peak_freq;
    logic [fcpdm_pkg::ByteW-1:0] peak_hour;
    logic [fcpdm_pkg::ByteW-1:0] peak_minute;
    logic [fcpdm_pkg::ByteW-1:0] peak_second;

    // predictor state
    logic [fcpdm_pkg::LimW-1:0]        limit_setting;
    logic signed [fcpdm_pkg::OffW-1:0] offset_setting;
    logic [fcpdm_pkg::PeakW-1:0]       peak_level;
    logic [fcpdm_pkg::ByteW-1:0]       peak_at_hour;
    logic [fcpdm_pkg::ByteW-1:0]       peak_at_minute;
    logic [fcpdm_pkg::ByteW-1:0]       peak_at_second;

    reading_t  expected_readings[$];
    plan_row_t plan_rows[$];
    int        readings_sent = 0;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    bit        long_hold_req = 1'b0;

    frequency_calibrate_peak_dac_map_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_freq       (raw_freq),
        .clock_hour     (clock_hour),
        .clock_minute   (clock_minute),
        .clock_second   (clock_second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .calibrated_freq(calibrated_freq),
        .dac_code       (dac_code),
        .peak_freq      (peak_freq),
        .peak_hour      (peak_hour),
        .peak_minute    (peak_minute),
        .peak_second    (peak_second)
    );

    always #HalfPeriod clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_readings.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // returns 0 when the refresh is dropped, else the reading after the peak update
    function automatic bit calibrate_and_map(input logic [fcpdm_pkg::RawW-1:0] raw,
                                             input logic [fcpdm_pkg::ByteW-1:0] hr, mn, sc,
                                             output reading_t r);
        int f;
        int lim;
        int num;
        if (raw > fcpdm_pkg::RawMax)
            return 1'b0;
        f = int'(raw) + int'(offset_setting);
        if (f > int'(fcpdm_pkg::CalMax))
            f = int'(fcpdm_pkg::CalMax);
        if (f > 0 && f > int'(peak_level))
        begin
            peak_level     = f[fcpdm_pkg::PeakW-1:0];
            peak_at_hour   = hr;
            peak_at_minute = mn;
            peak_at_second = sc;
        end
        lim = int'(limit_setting);
        r.cal = f[fcpdm_pkg::CalW-1:0];
        if (f < 0)
            r.code = fcpdm_pkg::ZeroCode;
        else if (f < int'(fcpdm_pkg::LowFreq))
            r.code = fcpdm_pkg::LowCode;
        else if (lim <= int'(fcpdm_pkg::LimFloor) || f > lim)
            r.code = fcpdm_pkg::FullCode;
        else
        begin
            num = 4 * f + lim - int'(fcpdm_pkg::LinearBias);
            r.code = fcpdm_pkg::CodeW'((num * int'(fcpdm_pkg::LowCode))
                                       / (lim - int'(fcpdm_pkg::LimFloor)));
        end
        r.peak   = peak_level;
        r.hour   = peak_at_hour;
        r.minute = peak_at_minute;
        r.second = peak_at_second;
        return 1'b1;
    endfunction

    function automatic void add_refresh(input int raw, input int hr, mn, sc);
        plan_row_t row;
        row.kind  = PLAN_REFRESH;
        row.raw   = fcpdm_pkg::RawW'(raw);
        row.hr    = fcpdm_pkg::ByteW'(hr);
        row.mn    = fcpdm_pkg::ByteW'(mn);
        row.sc    = fcpdm_pkg::ByteW'(sc);
        row.typed = 1'b0;
        row.limit = '0;
        row.offset = '0;
        plan_rows.push_back(row);
    endfunction

    function automatic void add_checked(input int raw, input int hr, mn, sc,
                                        input int cal, code, pk, ph, pm, ps);
        add_refresh(raw, hr, mn, sc);
        plan_rows[$].typed       = 1'b1;
        plan_rows[$].want.cal    = fcpdm_pkg::CalW'(cal);
        plan_rows[$].want.code   = fcpdm_pkg::CodeW'(code);
        plan_rows[$].want.peak   = fcpdm_pkg::PeakW'(pk);
        plan_rows[$].want.hour   = fcpdm_pkg::ByteW'(ph);
        plan_rows[$].want.minute = fcpdm_pkg::ByteW'(pm);
        plan_rows[$].want.second = fcpdm_pkg::ByteW'(ps);
    endfunction

    function automatic void add_write(input int lim, input int off);
        plan_row_t row;
        row.kind   = PLAN_WRITE;
        row.raw    = '0;
        row.hr     = '0;
        row.mn     = '0;
        row.sc     = '0;
        row.typed  = 1'b0;
        row.limit  = fcpdm_pkg::LimW'(lim);
        row.offset = fcpdm_pkg::LimW'(off);
        plan_rows.push_back(row);
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // offer one refresh request, predict it at acceptance, then maybe idle
    task automatic offer_refresh(input logic [fcpdm_pkg::RawW-1:0] raw,
                                 input logic [fcpdm_pkg::ByteW-1:0] hr, mn, sc,
                                 input bit typed, input reading_t typed_want);
        reading_t predicted;
        int gap;
        in_valid     <= 1'b1;
        raw_freq     <= raw;
        clock_hour   <= hr;
        clock_minute <= mn;
        clock_second <= sc;
        do @(posedge clk); while (!in_ready);
        if (calibrate_and_map(raw, hr, mn, sc, predicted))
        begin
            expected_readings.push_back(typed ? typed_want : predicted);
            readings_sent++;
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            gap = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        // extra idle margin; a dropped request never enters the sequencer
        repeat (SettleCycles) @(posedge clk);
    endtask

    // both registers in one pass so cfg_valid stays high between the two requests
    task automatic write_settings(input logic [fcpdm_pkg::LimW-1:0] lim,
                                  input logic [fcpdm_pkg::LimW-1:0] off);
        cfg_valid <= 1'b1;
        cfg_index <= fcpdm_pkg::CFG_UPPER_LIMIT;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        limit_setting = lim;
        cfg_index <= fcpdm_pkg::CFG_CAL_OFFSET;
        cfg_data  <= off;
        do @(posedge clk); while (!cfg_ready);
        offset_setting = off[fcpdm_pkg::OffW-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic walk_plan();
        foreach (plan_rows[i])
        begin
            if (plan_rows[i].kind == PLAN_WRITE)
            begin
                wait_until_drained();
                write_settings(plan_rows[i].limit, plan_rows[i].offset);
            end
            else
                offer_refresh(plan_rows[i].raw, plan_rows[i].hr, plan_rows[i].mn,
                              plan_rows[i].sc, plan_rows[i].typed, plan_rows[i].want);
        end
        plan_rows.delete();
    endtask

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none, actual %0d",
                         $time, calibrated_freq);
                mismatch_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                compare_field("calibrated_freq", want.cal, calibrated_freq);
                compare_field("dac_code", want.code, dac_code);
                compare_field("peak_freq", want.peak, peak_freq);
                compare_field("peak_hour", want.hour, peak_hour);
                compare_field("peak_minute", want.minute, peak_minute);
                compare_field("peak_second", want.second, peak_second);
            end
        end
    end

    // receiver: stall modes of random length, plus long hold-offs on request
    initial
    begin : receiver
        stall_mode_t mode;
        int mode_left;
        int hold_left;
        int tick;
        out_ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LongHold;
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:     out_ready <= 1'b1;
                    RX_RANDOM:   out_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ready <= ((tick % 5) >= 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        reading_t no_reading;
        logic [fcpdm_pkg::LimW-1:0] lim_data;
        logic [fcpdm_pkg::LimW-1:0] off_data;
        int goal;
        int pick;
        int target;
        int lim_i;
        int off_i;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = fcpdm_pkg::CFG_UPPER_LIMIT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        raw_freq     = '0;
        clock_hour   = '0;
        clock_minute = '0;
        clock_second = '0;
        no_reading   = '{cal: '0, code: '0, peak: '0, hour: '0, minute: '0, second: '0};
        limit_setting  = fcpdm_pkg::LimReset;
        offset_setting = fcpdm_pkg::OffReset;
        peak_level     = '0;
        peak_at_hour   = '0;
        peak_at_minute = '0;
        peak_at_second = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: limit 2000, offset 0, peak kept low for the random part
        add_checked(0, 'h00, 'h00, 'h00, 0, 51, 0, 'h00, 'h00, 'h00);
        add_checked(499, 'h12, 'h34, 'h56, 499, 51, 499, 'h12, 'h34, 'h56);
        add_checked(500, 'h01, 'h02, 'h03, 500, 51, 500, 'h01, 'h02, 'h03);
        add_checked(2000, 'h23, 'h59, 'h59, 2000, 255, 2000, 'h23, 'h59, 'h59);
        add_checked(2001, 'h00, 'h00, 'h01, 2001, 255, 2001, 'h00, 'h00, 'h01);
        // equal to the peak: peak and its clock bytes stay
        add_checked(2001, 'h11, 'h22, 'h33, 2001, 255, 2001, 'h00, 'h00, 'h01);
        add_refresh(1250, 'h05, 'h06, 'h07);
        // above the raw limit: dropped
        add_refresh(31868, 'h08, 'h09, 'h10);
        add_refresh(65535, 'hff, 'hff, 'hff);
        add_write(2000, -1024);
        add_checked(0, 'h01, 'h01, 'h01, -1024, 0, 2001, 'h00, 'h00, 'h01);
        add_checked(1523, 'h02, 'h02, 'h02, 499, 51, 2001, 'h00, 'h00, 'h01);
        add_checked(1024, 'h03, 'h03, 'h03, 0, 51, 2001, 'h00, 'h00, 'h01);
        // limit at or below the floor: no division, full scale unless f is below 500
        add_write(0, 0);
        add_checked(500, 'h04, 'h04, 'h04, 500, 255, 2001, 'h00, 'h00, 'h01);
        add_checked(499, 'h05, 'h05, 'h05, 499, 51, 2001, 'h00, 'h00, 'h01);
        add_write(500, 0);
        add_checked(600, 'h06, 'h06, 'h06, 600, 255, 2001, 'h00, 'h00, 'h01);
        add_write(501, 0);
        add_checked(501, 'h07, 'h07, 'h07, 501, 255, 2001, 'h00, 'h00, 'h01);
        add_checked(500, 'h08, 'h08, 'h08, 500, 51, 2001, 'h00, 'h00, 'h01);
        add_write(16383, 0);
        add_checked(500, 'h09, 'h09, 'h09, 500, 51, 2001, 'h00, 'h00, 'h01);
        add_refresh(1999, 'h10, 'h10, 'h10);
        add_write(9000, 900);
        add_refresh(1000, 'h11, 'h11, 'h11);
        add_write(1000, -900);
        add_checked(1400, 'h12, 'h12, 'h12, 500, 51, 2001, 'h00, 'h00, 'h01);
        add_refresh(1650, 'h13, 'h13, 'h13);
        add_checked(2000, 'h14, 'h14, 'h14, 1100, 255, 2001, 'h00, 'h00, 'h01);
        walk_plan();

        for (int phase = 0; phase < PhaseCount; phase++)
        begin
            wait_until_drained();
            if (phase == 0)
            begin
                lim_data = fcpdm_pkg::LimW'(1000);
                off_data = fcpdm_pkg::LimW'(-900);
            end
            else if (phase == 1)
            begin
                lim_data = fcpdm_pkg::LimW'(9000);
                off_data = fcpdm_pkg::LimW'(900);
            end
            else
            begin
                lim_data = ($urandom_range(0, 4) == 0)
                         ? fcpdm_pkg::LimW'($urandom_range(0, 16383))
                         : fcpdm_pkg::LimW'(1000 * $urandom_range(1, 9));
                off_data = ($urandom_range(0, 4) == 0)
                         ? fcpdm_pkg::LimW'($urandom_range(0, 2047))
                         : fcpdm_pkg::LimW'(100 * $urandom_range(0, 18) - 900);
            end
            // bits above the offset field carry no meaning
            off_data[fcpdm_pkg::LimW-1:fcpdm_pkg::OffW] =
                (fcpdm_pkg::LimW - fcpdm_pkg::OffW)'($urandom_range(0, 7));
            write_settings(lim_data, off_data);
            if (phase == 3 || phase == 8)
            begin
                // receiver holds off while the sender keeps requests coming
                long_hold_req = 1'b1;
                burst_left = 60;
            end
            lim_i = int'(limit_setting);
            off_i = int'(offset_setting);
            goal = readings_sent + ItemsPerPhase;
            while (readings_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    target = $urandom_range(int'(fcpdm_pkg::RawMax) + 1, 65535);
                else if (pick < 50)
                    target = int'(peak_level) - off_i + $urandom_range(0, 60) - 20;
                else if (pick < 85)
                    target = $urandom_range(0, lim_i + 800) - off_i;
                else if (pick < 95 || phase < PhaseCount - 2)
                    target = $urandom_range(0, 1100);
                else
                    target = $urandom_range(0, int'(fcpdm_pkg::RawMax));
                if (pick >= 10)
                begin
                    if (target < 0)
                        target = 0;
                    if (target > int'(fcpdm_pkg::RawMax))
                        target = int'(fcpdm_pkg::RawMax);
                end
                offer_refresh(fcpdm_pkg::RawW'(target),
                              fcpdm_pkg::ByteW'($urandom_range(0, 255)),
                              fcpdm_pkg::ByteW'($urandom_range(0, 255)),
                              fcpdm_pkg::ByteW'($urandom_range(0, 255)), 1'b0, no_reading);
            end
        end

        // high end last, since the peak never comes back down
        add_write(16383, 0);
        add_refresh(16383, 'h21, 'h43, 'h05);
        add_write(9000, 900);
        add_refresh(8100, 'h22, 'h44, 'h06);
        add_write(2000, 1023);
        add_refresh(31867, 'hff, 'hff, 'hff);
        add_refresh(31867, 'h12, 'h34, 'h56);
        add_refresh(31000, 'h00, 'h00, 'h00);
        walk_plan();

        wait_until_drained();
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
